FILE: sv/rv64_word_alu_muldiv_macros.svh
// assertion helpers used by the top-level module
`ifndef RV64_WORD_ALU_MULDIV_MACROS_SVH
`define RV64_WORD_ALU_MULDIV_MACROS_SVH

// condition implies consequence in the same cycle
`define RVW_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("rvw check failed");

// condition implies consequence in the next cycle
`define RVW_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("rvw check failed");

`endif

FILE: sv/rvw_pkg.sv
package rvw_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned XLEN   = 64;
	localparam int unsigned REG_W  = 5;
	localparam int unsigned SH_W   = 5;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULD = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_DIV  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_REM  = 3'd6;
	localparam logic [2:0] F3_REMU = 3'd7;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_SLL, OP_SRL, OP_SRA,
		OP_DIV, OP_DIVU, OP_REM, OP_REMU
	} op_t;

	// decoded instruction handed from front to back
	typedef struct packed {
		op_t                op;
		logic [WORD_W-1:0]  a;
		logic [WORD_W-1:0]  b;
		logic [REG_W-1:0]   rd;
		logic               illegal;
	} dec_t;

	// fields that ride along the divide pipeline
	typedef struct packed {
		op_t                op;
		logic [REG_W-1:0]   rd;
		logic               illegal;
		logic [WORD_W-1:0]  res;
		logic [WORD_W-1:0]  dvs;
		logic [WORD_W-1:0]  a;
		logic               negq;
		logic               negr;
		logic               zero;
	} pass_t;

endpackage

FILE: sv/rvw_req_if.sv
interface rvw_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;
	logic [63:0] first_operand;
	logic [63:0] second_operand;

	modport source (output valid, instruction_word, first_operand, second_operand,
		input ready);
	modport sink (input valid, instruction_word, first_operand, second_operand,
		output ready);
endinterface

FILE: sv/rvw_rsp_if.sv
interface rvw_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic [4:0]  dest_register;
	logic        illegal;

	modport source (output valid, result_value, dest_register, illegal, input ready);
	modport sink (input valid, result_value, dest_register, illegal, output ready);
endinterface

FILE: sv/rvw_front.sv
module rvw_front (
	input  logic [31:0]   instruction_word,
	input  logic [63:0]   first_operand,
	input  logic [63:0]   second_operand,
	output rvw_pkg::dec_t dec
);

	logic [2:0] f3;
	logic [6:0] f7;

	assign f3 = instruction_word[14:12];
	assign f7 = instruction_word[31:25];

	// funct3 / funct7 decode
	always_comb begin
		dec.a       = first_operand[rvw_pkg::WORD_W-1:0];
		dec.b       = second_operand[rvw_pkg::WORD_W-1:0];
		dec.rd      = instruction_word[11:7];
		dec.op      = rvw_pkg::OP_ADD;
		dec.illegal = 1'b0;
		case (f3)
			rvw_pkg::F3_ADD: begin
				if (f7 == rvw_pkg::F7_BASE) dec.op = rvw_pkg::OP_ADD;
				else if (f7 == rvw_pkg::F7_MULD) dec.op = rvw_pkg::OP_MUL;
				else if (f7 == rvw_pkg::F7_ALT) dec.op = rvw_pkg::OP_SUB;
				else dec.illegal = 1'b1;
			end
			rvw_pkg::F3_SLL: dec.op = rvw_pkg::OP_SLL;
			rvw_pkg::F3_DIV: dec.op = rvw_pkg::OP_DIV;
			rvw_pkg::F3_SR: begin
				if (f7 == rvw_pkg::F7_BASE) dec.op = rvw_pkg::OP_SRL;
				else if (f7 == rvw_pkg::F7_MULD) dec.op = rvw_pkg::OP_DIVU;
				else if (f7 == rvw_pkg::F7_ALT) dec.op = rvw_pkg::OP_SRA;
				else dec.illegal = 1'b1;
			end
			rvw_pkg::F3_REM:  dec.op = rvw_pkg::OP_REM;
			rvw_pkg::F3_REMU: dec.op = rvw_pkg::OP_REMU;
			default: dec.illegal = 1'b1;
		endcase
	end

endmodule

FILE: sv/rvw_queue.sv
module rvw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rvw_pkg::dec_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output rvw_pkg::dec_t head_data
);

	rvw_pkg::dec_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: sv/rvw_back.sv
module rvw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  rvw_pkg::dec_t head_data,
	output logic          pop,
	rvw_rsp_if.source     rsp
);

	localparam int unsigned W = rvw_pkg::WORD_W;

	logic en;

	logic           val_s [0:W];
	rvw_pkg::pass_t pass_s [0:W];
	logic [W-1:0]   dvd_s [0:W];
	logic [W-1:0]   rem_s [0:W];

	logic           out_valid_q;
	logic [rvw_pkg::XLEN-1:0]  out_res_q;
	logic [rvw_pkg::REG_W-1:0] out_rd_q;
	logic           out_ill_q;

	// whole pipe advances unless the output register is held
	assign en  = ~out_valid_q | rsp.ready;
	assign pop = en & head_valid;

	// first stage: simple ops, multiply, divide operand prep
	logic [W-1:0]          simple_res;
	logic                  is_sdiv;
	logic                  sa;
	logic                  sb;
	logic [rvw_pkg::SH_W-1:0] sh;

	assign sh      = head_data.b[rvw_pkg::SH_W-1:0];
	assign is_sdiv = (head_data.op == rvw_pkg::OP_DIV) || (head_data.op == rvw_pkg::OP_REM);
	assign sa      = is_sdiv & head_data.a[W-1];
	assign sb      = is_sdiv & head_data.b[W-1];

	always_comb begin
		case (head_data.op)
			rvw_pkg::OP_ADD: simple_res = head_data.a + head_data.b;
			rvw_pkg::OP_SUB: simple_res = head_data.a - head_data.b;
			rvw_pkg::OP_MUL: simple_res = head_data.a * head_data.b;
			rvw_pkg::OP_SLL: simple_res = head_data.a << sh;
			rvw_pkg::OP_SRL: simple_res = head_data.a >> sh;
			rvw_pkg::OP_SRA: simple_res = W'($signed(head_data.a) >>> sh);
			default:         simple_res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) val_s[0] <= 1'b0;
		else if (en) val_s[0] <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s[0].op      <= head_data.op;
			pass_s[0].rd      <= head_data.rd;
			pass_s[0].illegal <= head_data.illegal;
			pass_s[0].res     <= simple_res;
			pass_s[0].dvs     <= sb ? -head_data.b : head_data.b;
			pass_s[0].a       <= head_data.a;
			pass_s[0].negq    <= sa ^ sb;
			pass_s[0].negr    <= sa;
			pass_s[0].zero    <= (head_data.b == '0);
			dvd_s[0]          <= sa ? -head_data.a : head_data.a;
			rem_s[0]          <= '0;
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar k = 1; k <= W; k++) begin : g_step
		logic [W:0] trial;
		logic [W:0] diff;

		assign trial = {rem_s[k-1], dvd_s[k-1][W-1]};
		assign diff  = trial - {1'b0, pass_s[k-1].dvs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) val_s[k] <= 1'b0;
			else if (en) val_s[k] <= val_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pass_s[k] <= pass_s[k-1];
				if (!diff[W]) begin
					rem_s[k] <= diff[W-1:0];
					dvd_s[k] <= {dvd_s[k-1][W-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial[W-1:0];
					dvd_s[k] <= {dvd_s[k-1][W-2:0], 1'b0};
				end
			end
		end
	end

	// sign fixup and divide-by-zero results
	logic [W-1:0] word_res;
	rvw_pkg::pass_t last;

	assign last = pass_s[W];

	always_comb begin
		case (last.op)
			rvw_pkg::OP_DIV:  word_res = last.zero ? '1 :
				(last.negq ? -dvd_s[W] : dvd_s[W]);
			rvw_pkg::OP_DIVU: word_res = last.zero ? '1 : dvd_s[W];
			rvw_pkg::OP_REM:  word_res = last.zero ? last.a :
				(last.negr ? -rem_s[W] : rem_s[W]);
			rvw_pkg::OP_REMU: word_res = last.zero ? last.a : rem_s[W];
			default:          word_res = last.res;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= val_s[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q <= last.illegal ? '0 : {{(rvw_pkg::XLEN-W){word_res[W-1]}}, word_res};
			out_rd_q  <= last.rd;
			out_ill_q <= last.illegal;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_value  = out_res_q;
	assign rsp.dest_register = out_rd_q;
	assign rsp.illegal       = out_ill_q;

endmodule

FILE: sv/rv64_word_alu_muldiv.sv
// channel | dir | payload
// req     | in  | instruction_word[31:0], first_operand[63:0], second_operand[63:0]
// rsp     | out | result_value[63:0], dest_register[4:0], illegal
//
// one transfer per cycle on each side when not stalled
// the path runs through the queue, operand stage, 32 divide steps and output register;
// every op walks the full divide pipeline so results stay in order
// arst_n clears queue count and all stage valid bits
// a held output freezes the back pipe; the two-entry queue keeps req ready until it fills
`include "rv64_word_alu_muldiv_macros.svh"

module rv64_word_alu_muldiv (
	input  logic      clk,
	input  logic      arst_n,
	rvw_req_if.sink   req,
	rvw_rsp_if.source rsp
);

	rvw_pkg::dec_t dec;
	rvw_pkg::dec_t head_data;
	logic          full;
	logic          head_valid;
	logic          pop;
	logic          push;

	assign req.ready = ~full;
	assign push      = req.valid & ~full;

	rvw_front u_front (
		.instruction_word (req.instruction_word),
		.first_operand    (req.first_operand),
		.second_operand   (req.second_operand),
		.dec              (dec)
	);

	rvw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (dec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	rvw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.rsp        (rsp)
	);

	// illegal results are zero, legal ones are sign-extended words
	`RVW_ASSERT_SAME(a_ill_zero, clk, arst_n, rsp.valid && rsp.illegal, rsp.result_value == 64'd0)
	`RVW_ASSERT_SAME(a_sext, clk, arst_n, rsp.valid,
		(&rsp.result_value[63:31]) || !(|rsp.result_value[63:31]))
	// a full queue cannot stay full after a free output slot
	`RVW_ASSERT_NEXT(a_drain, clk, arst_n, full && rsp.ready && !req.valid, !full)

endmodule
